// ===== hw/rtl/i2p_pkg.sv =====
`timescale 1ns / 1ps
// i2p_pkg: payload types, controller/datapath command and status structs,
// character codes and precedence helpers for the infix-to-postfix converter.
// no dependencies
package i2p_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expression;
    } item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       last_of_run;
        logic       expression_done;
        logic       overflow_seen;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture an accepted request
        logic emit_sym;   // emit the captured symbol
        logic pop_emit;   // emit the stack top and pop it
        logic push;       // push the captured symbol
        logic discard;    // pop the stack top without emitting
        logic finish;     // release the held result as the last of the run
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_operand;
        logic is_lparen;
        logic is_rparen;
        logic eoe;
        logic count_zero;
        logic top_lparen;
        logic op_pops;
        logic top_ok;
        logic emit_ok;
        logic finish_ok;
        logic pend_valid;
    } status_t;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // precedence as an unsigned rank: -1 -> 0, 1 -> 1, 2 -> 2, 3 -> 3
    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;
    localparam logic [1:0] RANK_POW  = 2'd3;

    function automatic logic [1:0] prec_rank(input logic [7:0] ch);
        logic [1:0] r;
        case (ch) inside
            CH_CARET:           r = RANK_POW;
            CH_STAR, CH_SLASH:  r = RANK_MUL;
            CH_PLUS, CH_MINUS:  r = RANK_ADD;
            default:            r = RANK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        logic r;
        case (ch) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: r = 1'b1;
            default:                                     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/i2p_ram.sv =====
`timescale 1ns / 1ps
// i2p_ram: generic single-write, single-read ram with registered read data
// no dependencies
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/i2p_datapath.sv =====
`timescale 1ns / 1ps
// i2p_datapath: captured request, operator stack with count and overflow flag,
// held result and output register. depends on i2p_pkg and i2p_ram
module i2p_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  i2p_pkg::cmd_t    cmd,
    output i2p_pkg::status_t status,
    input  i2p_pkg::item_t   sym,
    input  logic             res_ready,
    output logic             res_valid,
    output i2p_pkg::result_t res
);
    import i2p_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    item_t           item_reg;
    logic [CW-1:0]   count_reg, count_next, count_m1;
    logic            flag_reg, flag_next;
    logic            top_ok_reg, top_ok_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_reg, pend_next;
    logic            res_valid_reg, res_valid_next;
    result_t         res_reg, res_next;

    logic [7:0]      top;
    logic            full, emit, move, out_free, wr_en;
    logic [7:0]      emit_val;

    assign count_m1 = count_reg - CW'(1);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign wr_en    = cmd.push & ~full;

    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (item_reg.symbol),
        .raddr (count_m1[AW-1:0]),
        .rdata (top)
    );

    assign out_free = ~res_valid_reg | res_ready;
    assign emit     = cmd.emit_sym | cmd.pop_emit;
    assign emit_val = cmd.pop_emit ? top : item_reg.symbol;
    assign move     = (emit & pend_valid_reg) | cmd.finish;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_emit | cmd.discard)
        begin
            count_next = count_m1;
        end

        flag_next   = flag_reg | (cmd.push & full);
        // read data is registered from the count, so it trails every change of the count
        top_ok_next = ~(cmd.push | cmd.pop_emit | cmd.discard);

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_next       = emit_val;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end

        res_next = res_reg;
        if (move)
        begin
            res_next.out_symbol      = pend_reg;
            res_next.last_of_run     = cmd.finish;
            res_next.expression_done = cmd.finish & item_reg.end_of_expression;
            res_next.overflow_seen   = flag_reg;
        end

        if (move)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            flag_reg       <= 1'b0;
            top_ok_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            top_ok_reg     <= top_ok_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= sym;
        end
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        status.is_operand = is_operand(item_reg.symbol);
        status.is_lparen  = (item_reg.symbol == CH_LPAREN);
        status.is_rparen  = (item_reg.symbol == CH_RPAREN);
        status.eoe        = item_reg.end_of_expression;
        status.count_zero = (count_reg == '0);
        status.top_lparen = (top == CH_LPAREN);
        status.op_pops    = (count_reg != '0) &&
                            (prec_rank(item_reg.symbol) <= prec_rank(top));
        status.top_ok     = top_ok_reg;
        status.emit_ok    = ~pend_valid_reg | out_free;
        status.finish_ok  = out_free;
        status.pend_valid = pend_valid_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/i2p_ctrl.sv =====
`timescale 1ns / 1ps
// i2p_ctrl: sequencer for one request, drives datapath commands
// depends on i2p_pkg
module i2p_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sym_valid,
    output logic             sym_ready,
    input  i2p_pkg::status_t status,
    output i2p_pkg::cmd_t    cmd
);
    import i2p_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_RPAREN,
        S_OPPOP,
        S_FLUSH,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        sym_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sym_ready = 1'b1;
                if (sym_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (status.is_operand)
                begin
                    if (status.emit_ok)
                    begin
                        cmd.emit_sym = 1'b1;
                        state_next   = S_FLUSH;
                    end
                end
                else if (status.is_lparen)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_FLUSH;
                end
                else if (status.is_rparen)
                begin
                    state_next = S_RPAREN;
                end
                else
                begin
                    state_next = S_OPPOP;
                end
            end
            S_RPAREN:
            begin
                if (status.count_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (status.top_ok)
                begin
                    if (status.top_lparen)
                    begin
                        cmd.discard = 1'b1;
                        state_next  = S_FLUSH;
                    end
                    else if (status.emit_ok)
                    begin
                        cmd.pop_emit = 1'b1;
                    end
                end
            end
            S_OPPOP:
            begin
                if (status.top_ok)
                begin
                    if (status.op_pops)
                    begin
                        cmd.pop_emit = status.emit_ok;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!status.eoe || status.count_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (status.top_ok && status.emit_ok)
                begin
                    cmd.pop_emit = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.finish_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/infix_to_postfix_converter_top.sv =====
`timescale 1ns / 1ps
// infix_to_postfix_converter_top: shunting-yard converter, top level
// depends on i2p_pkg, i2p_ctrl, i2p_datapath (and i2p_ram below it)
//
// Takes one ASCII character per request on the sym channel and returns the
// postfix characters on the res channel, one per request. Letters and digits
// pass straight through, '(' and operators go onto an operator stack of
// STACK_DEPTH entries, ')' unwinds to its '(' and a character flagged as end
// of expression flushes the stack. Results of one input request are marked
// with last_of_run on the final one and expression_done on the final one of a
// flushed expression; overflow_seen is a sticky flag set when a push met a
// full stack and the character was dropped. An input request that produces
// nothing returns no result. Timing: one request is worked at a time. It
// passes through a capture state, a decode state and a release state, even
// when it yields no result, and through a flush step that has nothing to do
// when there is nothing to pop. Every pop waits for the new top, since the
// registered read port of the stack ram gives the new top only after each
// change of the stack count has been registered. The ')' loop and the
// operator loop end in a step that meets the '(' and discards it, meets a
// lower rank and pushes the operator, or meets an empty stack; the ')' loop
// and the flush see an empty stack from the count alone, without waiting for
// the read after their last pop, and a flush that follows a push first waits
// for the new top. Results wait in an output register, so a stalled consumer
// only holds the sequencer once a second result is ready.

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    // input character channel
    input  logic             sym_valid,
    output logic             sym_ready,
    input  i2p_pkg::item_t   sym,
    // postfix result channel
    output logic             res_valid,
    input  logic             res_ready,
    output i2p_pkg::result_t res
);
    import i2p_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: classify, pop loops, flush, final release
    i2p_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stack, flags, held result and output register
    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sym       (sym),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ===== tb/sv/i2p_checker.sv =====
`timescale 1ns / 1ps
// i2p_checker: watches both channels of the infix-to-postfix converter, predicts
// the postfix characters of every accepted request and compares the results.
// depends on i2p_pkg

module i2p_checker #(
    parameter int DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sym_valid,
    input  logic             sym_ready,
    input  i2p_pkg::item_t   sym,
    input  logic             res_valid,
    input  logic             res_ready,
    input  i2p_pkg::result_t res,
    output int               mismatches,
    output int               outstanding
);
    import i2p_pkg::*;

    localparam int PRINT_CAP = 60;

    // private copy of the converter state
    logic [7:0] op_stack [DEPTH];
    int         op_depth;
    logic       ovf_flag;

    logic [7:0] run_chars [$];
    result_t    expected_chars [$];
    int         miss_total = 0;

    assign mismatches = miss_total;

    task automatic report_mismatch(input string msg);
        if (miss_total < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        miss_total++;
    endtask

    function automatic int rank_of(input logic [7:0] ch);
        case (ch)
            CH_CARET:          return 3;
            CH_STAR, CH_SLASH: return 2;
            CH_PLUS, CH_MINUS: return 1;
            default:           return -1;
        endcase
    endfunction

    function automatic bit is_alnum(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
               (ch >= "0" && ch <= "9");
    endfunction

    function automatic void emit_top();
        run_chars.push_back(op_stack[op_depth - 1]);
        op_depth--;
    endfunction

    function automatic void push_op(input logic [7:0] ch);
        if (op_depth >= DEPTH)
            ovf_flag = 1'b1;
        else
        begin
            op_stack[op_depth] = ch;
            op_depth++;
        end
    endfunction

    // shunting-yard step for one request, appends its postfix characters
    function automatic void predict_postfix(input item_t req);
        int      prec;
        result_t r;
        run_chars.delete();
        if (is_alnum(req.symbol))
            run_chars.push_back(req.symbol);
        else if (req.symbol == CH_LPAREN)
            push_op(req.symbol);
        else if (req.symbol == CH_RPAREN)
        begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CH_LPAREN)
                emit_top();
            if (op_depth > 0)
                op_depth--;
        end
        else
        begin
            prec = rank_of(req.symbol);
            while (op_depth > 0 && prec <= rank_of(op_stack[op_depth - 1]))
                emit_top();
            push_op(req.symbol);
        end
        if (req.end_of_expression)
            while (op_depth > 0)
                emit_top();
        foreach (run_chars[k])
        begin
            r.out_symbol      = run_chars[k];
            r.last_of_run     = (k == run_chars.size() - 1);
            r.expression_done = r.last_of_run && req.end_of_expression;
            r.overflow_seen   = ovf_flag;
            expected_chars.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            op_depth = 0;
            ovf_flag = 1'b0;
            expected_chars.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a result can never belong to a request taken this edge
            if (res_valid && res_ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected result %02h", res.out_symbol));
                else
                begin
                    want = expected_chars.pop_front();
                    if (res.out_symbol !== want.out_symbol)
                        report_mismatch($sformatf("out_symbol %02h, wanted %02h",
                                                  res.out_symbol, want.out_symbol));
                    if (res.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, wanted %b on %02h",
                                                  res.last_of_run, want.last_of_run,
                                                  want.out_symbol));
                    if (res.expression_done !== want.expression_done)
                        report_mismatch($sformatf("expression_done %b, wanted %b on %02h",
                                                  res.expression_done, want.expression_done,
                                                  want.out_symbol));
                    if (res.overflow_seen !== want.overflow_seen)
                        report_mismatch($sformatf("overflow_seen %b, wanted %b on %02h",
                                                  res.overflow_seen, want.overflow_seen,
                                                  want.out_symbol));
                end
            end
            if (sym_valid && sym_ready)
                predict_postfix(sym);
            outstanding <= expected_chars.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: stimulus and verdict for infix_to_postfix_converter_top
// depends on i2p_pkg, i2p_checker and the converter rtl

module testbench;
    import i2p_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int RANDOM_FILL = 232;   // stream length before the overflow finale
    localparam int HOLD_CYCLES = 600;   // long receiver hold-off
    localparam int HOLD_AFTER  = 90;    // requests taken before the hold-off starts
    localparam int IDLE_LIMIT  = 5000;  // cycles without any handshake
    localparam int TAIL_CYCLES = 200;   // drain time after the last expected result

    logic    clk;
    logic    rst_n;
    logic    sym_valid;
    logic    sym_ready;
    item_t   sym;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    int      mismatches;
    int      outstanding;
    int      sym_taken = 0;

    item_t   char_stream [$];

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // prediction and comparison live in the checker, it only reports counts
    i2p_checker #(
        .DEPTH(STACK_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .sym         (sym),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // requests taken so far, used to time the receiver hold-off
    always @(posedge clk)
    begin
        if (rst_n && sym_valid && sym_ready)
            sym_taken <= sym_taken + 1;
    end

    // ------------------------------------------------------------------
    // stream building helpers
    // ------------------------------------------------------------------
    task automatic add_char(input logic [7:0] c, input logic eoe);
        item_t it;
        it.symbol            = c;
        it.end_of_expression = eoe;
        char_stream.push_back(it);
    endtask

    // flag the most recent character as the end of its expression
    task automatic end_expr();
        char_stream[char_stream.size() - 1].end_of_expression = 1'b1;
    endtask

    function automatic logic [7:0] pick_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return CH_CARET;
            1:       return CH_STAR;
            2:       return CH_SLASH;
            3:       return CH_PLUS;
            default: return CH_MINUS;
        endcase
    endfunction

    // term: operand or parenthesized subexpression; a broken term may
    // lose its closing parenthesis
    task automatic gen_term(input int nest, input bit broken);
        if (nest > 0 && $urandom_range(0, 3) == 0)
        begin
            add_char(CH_LPAREN, 1'b0);
            gen_expr(nest - 1, broken);
            if (!broken || $urandom_range(0, 2) != 0)
                add_char(CH_RPAREN, 1'b0);
        end
        else
            add_char(pick_operand(), 1'b0);
    endtask

    task automatic gen_expr(input int nest, input bit broken);
        int n_ops;
        n_ops = $urandom_range(0, 3);
        gen_term(nest, broken);
        repeat (n_ops)
        begin
            add_char(pick_operator(), 1'b0);
            gen_term(nest, broken);
        end
    endtask

    task automatic build_stream();
        int pick;
        // directed: precedence of '*' over '+'
        add_char("A", 1'b0); add_char(CH_PLUS, 1'b0); add_char("b", 1'b0);
        add_char(CH_STAR, 1'b0); add_char("9", 1'b1);
        // parentheses, all operator classes, operand extremes
        add_char(CH_LPAREN, 1'b0); add_char("z", 1'b0); add_char(CH_MINUS, 1'b0);
        add_char("0", 1'b0); add_char(CH_RPAREN, 1'b0); add_char(CH_SLASH, 1'b0);
        add_char("Z", 1'b0); add_char(CH_CARET, 1'b0); add_char("a", 1'b1);
        // unmatched closing parenthesis empties the stack
        add_char("a", 1'b0); add_char(CH_PLUS, 1'b0); add_char("b", 1'b0);
        add_char(CH_RPAREN, 1'b0); add_char("c", 1'b1);
        // unranked operator pops the open parenthesis too
        add_char(CH_LPAREN, 1'b0); add_char("a", 1'b0); add_char("#", 1'b0);
        add_char("b", 1'b1);
        // all-zero and all-one symbols act as unranked operators
        add_char(8'h00, 1'b1);
        add_char(8'hFF, 1'b1);
        // open parenthesis left at the end is flushed out
        add_char(CH_LPAREN, 1'b1);
        // end flag on a character with no output
        add_char(CH_RPAREN, 1'b1);

        // fill the stack exactly, then one operand flushes everything
        repeat (STACK_DEPTH)
            add_char(CH_LPAREN, 1'b0);
        add_char("x", 1'b1);

        // random part: mostly well-formed expressions, some broken, some noise
        while (char_stream.size() < RANDOM_FILL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                gen_expr(3, 1'b0);
                end_expr();
            end
            else if (pick < 8)
            begin
                gen_expr(3, 1'b1);
                if ($urandom_range(0, 1))
                    add_char(CH_RPAREN, 1'b0);
                if ($urandom_range(0, 1))
                    end_expr();
            end
            else
                repeat ($urandom_range(1, 4))
                    add_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        end

        // overflow last, since the flag sticks: clear the stack, then push past full
        add_char("q", 1'b1);
        repeat (STACK_DEPTH + 1)
            add_char(CH_LPAREN, 1'b0);
        add_char(CH_PLUS, 1'b0);
        add_char("y", 1'b1);
    endtask

    // ------------------------------------------------------------------
    // main sequence: reset, send requests in bursts, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        int idx;
        int burst;
        int gap;
        int k;
        rst_n     <= 1'b0;
        sym_valid <= 1'b0;
        sym       <= '0;
        build_stream();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < char_stream.size())
        begin
            // now and then a long burst with no gaps at all
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(40, 80);
            else
                burst = $urandom_range(1, 24);
            k = 0;
            while (k < burst && idx < char_stream.size())
            begin
                sym       <= char_stream[idx];
                sym_valid <= 1'b1;
                @(posedge clk);
                while (!sym_ready)
                    @(posedge clk);
                idx++;
                k++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                sym_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sym_valid <= 1'b0;

        // wait for every predicted character, then give stray results a chance
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stretches of steady, random and sparse ready, plus one
    // long hold-off while the sender keeps offering requests
    // ------------------------------------------------------------------
    initial
    begin
        bit held_off;
        int mode;
        int span;
        held_off = 1'b0;
        res_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && sym_taken >= HOLD_AFTER)
            begin
                // the output register fills and the input side stalls
                held_off = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span)
                begin
                    case (mode)
                        0:       res_ready <= 1'b1;
                        1:       res_ready <= ($urandom_range(0, 1) == 1);
                        2:       res_ready <= ($urandom_range(0, 4) != 0);
                        default: res_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sym_valid && sym_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
